// ===== src/tdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants of the TPDF dither quantizer.
// ----------------------------------------------------------------------------
package tdq_pkg;

    // Register indexes on the configuration port.
    localparam logic REG_FORMAT   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    // Noise generator constants.
    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_ADD    = 32'd12345;
    localparam logic [31:0] LCG_SEED   = 32'd1;
    localparam logic [32:0] NOISE_STEP = 33'd26215;

    // Quantizer limits and the rounding offset (half an LSB in Q30).
    localparam logic [23:0] LIM16    = 24'd32767;
    localparam logic [23:0] LIM24    = 24'd8388607;
    localparam logic [55:0] HALF_Q30 = 56'd1 << 29;

    // Datapath widths.
    localparam int MUL_W   = 33;  // signed operand width of the shared multiplier
    localparam int PROD_W  = 66;
    localparam int DITH_W  = 17;  // difference of two 15-bit draws
    localparam int NOISE_W = 31;  // dither times the noise step
    localparam int PSAMP_W = 56;  // sample times limit
    localparam int SUM_W   = 57;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture an accepted input sample
        logic draw_a;      // first LCG draw of a frame
        logic draw_b;      // second LCG draw, forms the dither value
        logic noise_mul;   // dither times the noise step
        logic sample_mul;  // sample times the format limit
        logic sum;         // add noise to the scaled sample
        logic round;       // round, saturate, load the output and advance position
    } tdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_chan;  // current position is the first channel of a frame
    } tdq_stat_t;

endpackage

// ===== src/tdq_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_regs
// APB configuration registers: output format and channel count.
// ----------------------------------------------------------------------------
module tdq_regs
    import tdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        fmt24,
    output logic [3:0]  chan_count
);

    logic       fmt_reg;
    logic       fmt_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes at the access cycle of a write request.
    always_comb begin
        fmt_next   = fmt_reg;
        count_next = count_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_FORMAT:   fmt_next   = pwdata[0];
                REG_CHANNELS: count_next = pwdata[3:0];
                default:      fmt_next   = fmt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= 1'b0;
            count_reg <= 4'd2;
        end else begin
            fmt_reg   <= fmt_next;
            count_reg <= count_next;
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[2])
            REG_FORMAT:   prdata = {31'd0, fmt_reg};
            REG_CHANNELS: prdata = {28'd0, count_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign fmt24      = fmt_reg;
    assign chan_count = count_reg;

endmodule

// ===== src/tdq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_dp
// Datapath: LCG noise source, shared multiplier, rounding and saturation,
// channel and frame position counters, and the output payload register.
// ----------------------------------------------------------------------------
module tdq_dp
    import tdq_pkg::*;
#(
    parameter int NOISE_PERIOD = 131072,
    parameter int MAX_CHANNELS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tdq_cmd_t         cmd,
    output tdq_stat_t        stat,
    input  logic             fmt24,
    input  logic [3:0]       chan_count,
    input  logic [31:0]      sample_in,
    output logic [23:0]      sample_out,
    output logic [23:0]      packed_out,
    output logic [2:0]       channel_out
);

    localparam int FP_W = $clog2(NOISE_PERIOD + 1);
    localparam int CH_W = $clog2(MAX_CHANNELS + 1);

    // Noise state.
    logic [31:0]                lcg_reg;
    logic [14:0]                draw_a_reg;
    logic signed [DITH_W-1:0]   dith_reg;
    logic signed [NOISE_W-1:0]  noise_reg;
    logic [CH_W-1:0]            pos_reg;
    logic [FP_W-1:0]            frame_reg;

    // Sample path.
    logic signed [31:0]         x_reg;
    logic signed [PSAMP_W-1:0]  psamp_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [23:0]                out_samp_reg;
    logic [23:0]                out_pack_reg;
    logic [2:0]                 out_chan_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [31:0]                lcg_base;
    logic [31:0]                lcg_next;
    logic [23:0]                lim;

    logic                       v_neg;
    logic [PSAMP_W-1:0]         mag;
    logic [PSAMP_W-1:0]         mag_rnd;
    logic [25:0]                rmag;
    logic [23:0]                rsat;
    logic [24:0]                q;

    logic [7:0]                 chans;
    logic [7:0]                 pos_ext;
    logic [7:0]                 pos_inc;
    logic                       frame_end;

    assign lim = fmt24 ? LIM24 : LIM16;

    // Noise restarts from the seed at the first channel of frame zero.
    assign lcg_base = (frame_reg == '0) ? LCG_SEED : lcg_reg;

    // Shared multiplier operand selection.
    always_comb begin
        priority if (cmd.draw_a) begin
            mul_a = {1'b0, lcg_base};
            mul_b = {1'b0, LCG_MUL};
        end else if (cmd.draw_b) begin
            mul_a = {1'b0, lcg_reg};
            mul_b = {1'b0, LCG_MUL};
        end else if (cmd.noise_mul) begin
            mul_a = MUL_W'(dith_reg);
            mul_b = NOISE_STEP;
        end else begin
            mul_a = MUL_W'(x_reg);
            mul_b = {9'd0, lim};
        end
    end

    assign prod     = mul_a * mul_b;
    assign lcg_next = prod[31:0] + LCG_ADD;

    // Input capture, noise draws and the multiply and sum steps.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg <= sample_in;
        end
        if (cmd.draw_a) begin
            draw_a_reg <= lcg_next[30:16];
        end
        if (cmd.draw_b) begin
            dith_reg <= {2'b00, lcg_next[30:16]} - {2'b00, draw_a_reg};
        end
        if (cmd.sample_mul) begin
            psamp_reg <= prod[PSAMP_W-1:0];
        end
        if (cmd.sum) begin
            sum_reg <= SUM_W'(psamp_reg) + SUM_W'(noise_reg);
        end
    end

    // Round half away from zero on the magnitude, then saturate to the limit.
    assign v_neg   = sum_reg[SUM_W-1];
    assign mag     = v_neg ? PSAMP_W'(-sum_reg) : PSAMP_W'(sum_reg);
    assign mag_rnd = mag + HALF_Q30;
    assign rmag    = mag_rnd[55:30];
    assign rsat    = (rmag > {2'b00, lim}) ? lim : rmag[23:0];
    assign q       = v_neg ? (25'd0 - {1'b0, rsat}) : {1'b0, rsat};

    // Effective channel count: zero counts as one, capped at the maximum.
    always_comb begin
        priority if (chan_count == 4'd0) begin
            chans = 8'd1;
        end else if ({4'd0, chan_count} > 8'(MAX_CHANNELS)) begin
            chans = 8'(MAX_CHANNELS);
        end else begin
            chans = {4'd0, chan_count};
        end
    end

    assign pos_ext   = 8'(pos_reg);
    assign pos_inc   = pos_ext + 8'd1;
    assign frame_end = (pos_inc >= chans);

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            out_samp_reg <= q[23:0];
            out_pack_reg <= fmt24 ? q[23:0] : {8'd0, q[15:0]};
            out_chan_reg <= pos_ext[2:0];
        end
    end

    // Noise state and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg   <= LCG_SEED;
            noise_reg <= '0;
            pos_reg   <= '0;
            frame_reg <= '0;
        end else begin
            if (cmd.draw_a || cmd.draw_b) begin
                lcg_reg <= lcg_next;
            end
            if (cmd.noise_mul) begin
                noise_reg <= prod[NOISE_W-1:0];
            end
            if (cmd.round) begin
                if (frame_end) begin
                    pos_reg <= '0;
                    if (frame_reg == FP_W'(NOISE_PERIOD - 1)) begin
                        frame_reg <= '0;
                    end else begin
                        frame_reg <= frame_reg + 1'b1;
                    end
                end else begin
                    pos_reg <= pos_inc[CH_W-1:0];
                end
            end
        end
    end

    assign stat.first_chan = (pos_reg == '0);
    assign sample_out      = out_samp_reg;
    assign packed_out      = out_pack_reg;
    assign channel_out     = out_chan_reg;

endmodule

// ===== src/tdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl
// Controller: sequences noise draws, multiplies and rounding for each request,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module tdq_ctrl
    import tdq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  tdq_stat_t stat,
    output tdq_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DRAW_A = 3'd1;
    localparam logic [2:0] ST_DRAW_B = 3'd2;
    localparam logic [2:0] ST_NMUL   = 3'd3;
    localparam logic [2:0] ST_SMUL   = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;
    localparam logic [2:0] ST_RND    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       ovalid_reg;
    logic       ovalid_next;
    logic       out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !ovalid_reg || m_tready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = stat.first_chan ? ST_DRAW_A : ST_SMUL;
                end
            end
            ST_DRAW_A: begin
                cmd.draw_a = 1'b1;
                state_next = ST_DRAW_B;
            end
            ST_DRAW_B: begin
                cmd.draw_b = 1'b1;
                state_next = ST_NMUL;
            end
            ST_NMUL: begin
                cmd.noise_mul = 1'b1;
                state_next    = ST_SMUL;
            end
            ST_SMUL: begin
                cmd.sample_mul = 1'b1;
                state_next     = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                if (out_free) begin
                    cmd.round  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb begin
        ovalid_next = ovalid_reg && !m_tready;
        if (cmd.round) begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;

endmodule

// ===== src/tpdf_dither_quantizer_unit.sv =====
`timescale 1ns / 1ps
// Steps: a request at a frame's later channels runs the sample multiply, the sum
// and the rounding step; at a frame's first channel, two LCG draws and the noise
// multiply come first. The rounding step waits until the output is empty or drained.
// A new request is taken only after the last one has been rounded; all
// steps share one 33x33 multiplier. A result waiting at the output does not
// block the next request until its rounding step. Reset: synchronous, active low;
// noise restarts from seed 1, positions clear, format 16-bit, two channels.
// ----------------------------------------------------------------------------
// tpdf_dither_quantizer_unit
// TPDF-dithered 16/24-bit PCM quantizer for interleaved Q2.30 samples.
// ----------------------------------------------------------------------------
module tpdf_dither_quantizer_unit
    import tdq_pkg::*;
#(
    parameter int NOISE_PERIOD = 131072,
    parameter int MAX_CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_in
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] sample_out, [47:24] packed_out
    output logic [2:0]  m_tuser,   // [2:0] channel_out
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tdq_cmd_t    cmd;
    tdq_stat_t   stat;
    logic        fmt24;
    logic [3:0]  chan_count;
    logic [23:0] sample_out;
    logic [23:0] packed_out;

    // Configuration registers.
    tdq_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fmt24      (fmt24),
        .chan_count (chan_count)
    );

    // Step sequencer.
    tdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Noise, arithmetic and position state.
    tdq_dp #(
        .NOISE_PERIOD (NOISE_PERIOD),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .fmt24       (fmt24),
        .chan_count  (chan_count),
        .sample_in   (s_tdata),
        .sample_out  (sample_out),
        .packed_out  (packed_out),
        .channel_out (m_tuser)
    );

    assign m_tdata = {packed_out, sample_out};

endmodule
